[sv/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ALIGN_BYTES  = 8;
	localparam int HEADER_BYTES = 16;
	localparam int HDR_SIZE     = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int MAX_EXTENTS  = 64;
	localparam int MAX_GRANTS   = 64;
	localparam int EXT_IDX_W    = $clog2(MAX_EXTENTS);
	localparam int GNT_IDX_W    = $clog2(MAX_GRANTS);
	localparam int CNT_W        = 7;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_STATS = 2'd2,
		REQ_INIT  = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_ZERO        = 3'd1,
		ST_NO_FIT      = 3'd2,
		ST_NOT_ALLOC   = 3'd3,
		ST_UNINIT      = 3'd4,
		ST_ALREADY     = 3'd5,
		ST_TABLE_FULL  = 3'd6
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_R0_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_R0_BYTES     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_R1_BASE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_R1_BYTES     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_R2_BASE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_R2_BYTES     = 3'd6;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] req_size;
		logic [31:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [31:0]      granted_addr;
		logic [31:0]      free_bytes;
		logic [31:0]      occupied_bytes;
		logic [31:0]      heap_total_bytes;
		logic [31:0]      lowest_free_seen;
		logic [31:0]      alloc_successes;
		logic [31:0]      free_successes;
		logic [31:0]      largest_free;
		logic [31:0]      smallest_free;
		logic [CNT_W-1:0] extent_count;
	} res_t;

endpackage

[sv/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap manager with an address-ordered free extent table that
// coalesces on free, and a grant table for issued blocks
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | in        | in_valid / in_stall | in_data (req_t)
//  out     | out       | out_valid/out_stall | out_data (res_t)
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// one request at a time; each extent or grant visited takes a synchronous read
// of the extent or grant memory, then a compare
// allocate: a first-fit search, then a removal shift if the extent is used whole
// free: a lookup over up to 64 grant slots, then an ordered insert with merging
// statistics: a scan of the extent table; init: per region an overlap scan and an insert
// no clearing pass after reset; a stalled result stays in the output register
// and the next request, once taken, waits for it before its own result
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  req_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output res_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_DONE,
		S_ALC_CHK, S_ALC_RD, S_ALC_CMP, S_ALC_TAKE, S_ALC_FIN,
		S_REM_RD, S_REM_WR, S_SHU_RD, S_SHU_WR,
		S_INS_RD, S_INS_CMP, S_INS_DEC, S_INS_END,
		S_FRE_RD, S_FRE_CMP,
		S_INI_REG, S_INI_USE, S_OVL_RD, S_OVL_CMP, S_INI_TOT,
		S_STA_RD, S_STA_CMP
	} state_t;

	localparam logic [CNT_W-1:0] MAX_EXT_C = CNT_W'(MAX_EXTENTS);
	localparam logic [CNT_W-1:0] MAX_GNT_C = CNT_W'(MAX_GRANTS);
	localparam logic [31:0]      MIN_SPLIT = 32'(HDR_SIZE + ALIGN_BYTES);

	// configuration registers
	logic [1:0]  region_count_q;
	logic [31:0] rbase_q [3];
	logic [31:0] rbytes_q [3];

	// memories
	logic [63:0] ext_mem [MAX_EXTENTS];
	logic [63:0] gnt_mem [MAX_GRANTS];
	logic [63:0] ext_rd_q, gnt_rd_q;
	logic [EXT_IDX_W-1:0] ext_ra, ext_wa;
	logic [GNT_IDX_W-1:0] gnt_ra;
	logic        ext_we, gnt_we;
	logic [63:0] ext_wd, gnt_wd;

	state_t state_q, ret_q;
	req_t   req_q;
	logic [CNT_W-1:0] k_q, pos_q, used_q, count_q;
	logic [GNT_IDX_W-1:0] slot_q;
	logic [MAX_GRANTS-1:0] gvalid_q;
	logic [33:0] need_q;
	logic [31:0] cur_base_q, cur_len_q, prev_base_q, prev_len_q, nxt_base_q, nxt_len_q;
	logic [31:0] adj_q;
	logic [1:0]  region_q;
	logic [32:0] total_q;
	logic        ins_ok_q, ready_q, out_valid_q;
	logic [31:0] avail_q, min_avail_q, usable_q, atally_q, ftally_q;
	logic [31:0] granted_q, largest_q, smallest_q;
	status_t     status_q;
	res_t        out_q;

	logic [31:0] rd_base, rd_len, g_base, g_len;
	logic        split, jp, jn, slot_found;
	logic [31:0] glen;
	logic [GNT_IDX_W-1:0] free_slot;
	logic [31:0] sel_base, sel_bytes;

	assign rd_base = ext_rd_q[63:32];
	assign rd_len  = ext_rd_q[31:0];
	assign g_base  = gnt_rd_q[63:32];
	assign g_len   = gnt_rd_q[31:0];

	assign split = (cur_len_q - need_q[31:0]) >= MIN_SPLIT;
	assign glen  = split ? need_q[31:0] : cur_len_q;
	assign jp = (pos_q != '0) && (({1'b0, prev_base_q} + {1'b0, prev_len_q}) == {1'b0, cur_base_q});
	assign jn = (pos_q < used_q) && (({1'b0, cur_base_q} + {1'b0, cur_len_q}) == {1'b0, nxt_base_q});

	// lowest empty grant slot
	always_comb begin
		free_slot  = '0;
		slot_found = 1'b0;
		for (int i = MAX_GRANTS - 1; i >= 0; i--) begin
			if (!gvalid_q[i]) begin
				free_slot  = GNT_IDX_W'(i);
				slot_found = 1'b1;
			end
		end
	end

	always_comb begin
		case (region_q)
			2'd0: begin
				sel_base  = rbase_q[0];
				sel_bytes = rbytes_q[0];
			end
			2'd1: begin
				sel_base  = rbase_q[1];
				sel_bytes = rbytes_q[1];
			end
			2'd2: begin
				sel_base  = rbase_q[2];
				sel_bytes = rbytes_q[2];
			end
			default: begin
				sel_base  = '0;
				sel_bytes = '0;
			end
		endcase
	end

	// memory port control
	always_comb begin
		ext_ra = k_q[EXT_IDX_W-1:0];
		ext_we = 1'b0;
		ext_wa = k_q[EXT_IDX_W-1:0];
		ext_wd = ext_rd_q;
		gnt_ra = k_q[GNT_IDX_W-1:0];
		gnt_we = 1'b0;
		gnt_wd = {cur_base_q, glen};
		case (state_q)
			S_REM_RD: ext_ra = EXT_IDX_W'(k_q + CNT_W'(1));
			S_SHU_RD: begin
				ext_ra = EXT_IDX_W'(k_q - CNT_W'(1));
				if (k_q <= pos_q) begin
					ext_we = 1'b1;
					ext_wa = pos_q[EXT_IDX_W-1:0];
					ext_wd = {cur_base_q, cur_len_q};
				end
			end
			S_REM_WR, S_SHU_WR: ext_we = 1'b1;
			S_ALC_TAKE: begin
				gnt_we = 1'b1;
				if (split) begin
					ext_we = 1'b1;
					ext_wa = pos_q[EXT_IDX_W-1:0];
					ext_wd = {cur_base_q + need_q[31:0], cur_len_q - need_q[31:0]};
				end
			end
			S_INS_DEC: begin
				if (jp) begin
					ext_we = 1'b1;
					ext_wa = EXT_IDX_W'(pos_q - CNT_W'(1));
					ext_wd = {prev_base_q, prev_len_q + cur_len_q + (jn ? nxt_len_q : 32'd0)};
				end else if (jn) begin
					ext_we = 1'b1;
					ext_wa = pos_q[EXT_IDX_W-1:0];
					ext_wd = {cur_base_q, nxt_len_q + cur_len_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ext_we)
			ext_mem[ext_wa] <= ext_wd;
		ext_rd_q <= ext_mem[ext_ra];
		if (gnt_we)
			gnt_mem[slot_q] <= gnt_wd;
		gnt_rd_q <= gnt_mem[gnt_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
			for (int i = 0; i < 3; i++) begin
				rbase_q[i]  <= '0;
				rbytes_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_COUNT: region_count_q <= cfg_data[1:0];
				CFG_R0_BASE:      rbase_q[0]     <= cfg_data;
				CFG_R0_BYTES:     rbytes_q[0]    <= cfg_data;
				CFG_R1_BASE:      rbase_q[1]     <= cfg_data;
				CFG_R1_BYTES:     rbytes_q[1]    <= cfg_data;
				CFG_R2_BASE:      rbase_q[2]     <= cfg_data;
				CFG_R2_BYTES:     rbytes_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			req_q       <= '0;
			k_q         <= '0;
			pos_q       <= '0;
			used_q      <= '0;
			count_q     <= '0;
			slot_q      <= '0;
			gvalid_q    <= '0;
			need_q      <= '0;
			cur_base_q  <= '0;
			cur_len_q   <= '0;
			prev_base_q <= '0;
			prev_len_q  <= '0;
			nxt_base_q  <= '0;
			nxt_len_q   <= '0;
			adj_q       <= '0;
			region_q    <= '0;
			total_q     <= '0;
			ins_ok_q    <= 1'b0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
			avail_q     <= '0;
			min_avail_q <= '0;
			usable_q    <= '0;
			atally_q    <= '0;
			ftally_q    <= '0;
			granted_q   <= '0;
			largest_q   <= '0;
			smallest_q  <= '0;
			status_q    <= ST_OK;
			out_q       <= '0;
		end else begin
			// in S_DONE the output register is reloaded instead
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q      <= in_data;
						granted_q  <= '0;
						largest_q  <= '0;
						smallest_q <= '0;
						count_q    <= '0;
						status_q   <= ST_OK;
						k_q        <= '0;
						need_q     <= ({2'b0, in_data.req_size} + 34'(HDR_SIZE + ALIGN_BYTES - 1))
							& ~34'(ALIGN_BYTES - 1);
						state_q    <= S_DONE;
						case (req_kind_t'(in_data.req_type))
							REQ_ALLOC: begin
								if (!ready_q)
									status_q <= ST_UNINIT;
								else if (in_data.req_size == '0)
									status_q <= ST_ZERO;
								else
									state_q <= S_ALC_CHK;
							end
							REQ_FREE: begin
								if (!ready_q)
									status_q <= ST_UNINIT;
								else if (in_data.free_addr == '0)
									status_q <= ST_ZERO;
								else
									state_q <= S_FRE_RD;
							end
							REQ_INIT: begin
								if (ready_q)
									status_q <= ST_ALREADY;
								else begin
									used_q   <= '0;
									total_q  <= '0;
									region_q <= '0;
									state_q  <= S_INI_REG;
								end
							end
							default: state_q <= S_STA_RD;
						endcase
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q            <= 1'b1;
						out_q.status           <= status_q;
						out_q.granted_addr     <= granted_q;
						out_q.free_bytes       <= avail_q;
						out_q.occupied_bytes   <= usable_q - avail_q;
						out_q.heap_total_bytes <= usable_q;
						out_q.lowest_free_seen <= min_avail_q;
						out_q.alloc_successes  <= atally_q;
						out_q.free_successes   <= ftally_q;
						out_q.largest_free     <= largest_q;
						out_q.smallest_free    <= smallest_q;
						out_q.extent_count     <= count_q;
						state_q                <= S_IDLE;
					end
				end
				// allocate
				S_ALC_CHK: begin
					if (need_q > {2'b0, avail_q}) begin
						status_q <= ST_NO_FIT;
						state_q  <= S_DONE;
					end else
						state_q <= S_ALC_RD;
				end
				S_ALC_RD: begin
					if (k_q >= used_q) begin
						status_q <= ST_NO_FIT;
						state_q  <= S_DONE;
					end else
						state_q <= S_ALC_CMP;
				end
				S_ALC_CMP: begin
					if ({2'b0, rd_len} >= need_q) begin
						pos_q      <= k_q;
						cur_base_q <= rd_base;
						cur_len_q  <= rd_len;
						slot_q     <= free_slot;
						if (!slot_found) begin
							status_q <= ST_TABLE_FULL;
							state_q  <= S_DONE;
						end else
							state_q <= S_ALC_TAKE;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_ALC_RD;
					end
				end
				S_ALC_TAKE: begin
					gvalid_q[slot_q] <= 1'b1;
					cur_len_q        <= glen;
					granted_q        <= cur_base_q + 32'(HDR_SIZE);
					if (split)
						state_q <= S_ALC_FIN;
					else begin
						k_q     <= pos_q;
						ret_q   <= S_ALC_FIN;
						state_q <= S_REM_RD;
					end
				end
				S_ALC_FIN: begin
					avail_q  <= avail_q - cur_len_q;
					if ((avail_q - cur_len_q) < min_avail_q)
						min_avail_q <= avail_q - cur_len_q;
					atally_q <= atally_q + 32'd1;
					status_q <= ST_OK;
					state_q  <= S_DONE;
				end
				// close the gap at k by moving later entries down
				S_REM_RD: begin
					if ((k_q + CNT_W'(1)) < used_q)
						state_q <= S_REM_WR;
					else begin
						used_q  <= used_q - CNT_W'(1);
						state_q <= ret_q;
					end
				end
				S_REM_WR: begin
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_REM_RD;
				end
				// open a gap at pos by moving entries up, then fill it
				S_SHU_RD: begin
					if (k_q > pos_q)
						state_q <= S_SHU_WR;
					else begin
						used_q  <= used_q + CNT_W'(1);
						state_q <= ret_q;
					end
				end
				S_SHU_WR: begin
					k_q     <= k_q - CNT_W'(1);
					state_q <= S_SHU_RD;
				end
				// ordered insert with merging
				S_INS_RD: begin
					if (k_q >= used_q) begin
						pos_q   <= k_q;
						state_q <= S_INS_DEC;
					end else
						state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (rd_base < cur_base_q) begin
						prev_base_q <= rd_base;
						prev_len_q  <= rd_len;
						k_q         <= k_q + CNT_W'(1);
						state_q     <= S_INS_RD;
					end else begin
						pos_q      <= k_q;
						nxt_base_q <= rd_base;
						nxt_len_q  <= rd_len;
						state_q    <= S_INS_DEC;
					end
				end
				S_INS_DEC: begin
					ins_ok_q <= 1'b1;
					if (jp && jn) begin
						k_q     <= pos_q;
						ret_q   <= S_INS_END;
						state_q <= S_REM_RD;
					end else if (jp || jn)
						state_q <= S_INS_END;
					else if (used_q >= MAX_EXT_C) begin
						ins_ok_q <= 1'b0;
						state_q  <= S_INS_END;
					end else begin
						k_q     <= used_q;
						ret_q   <= S_INS_END;
						state_q <= S_SHU_RD;
					end
				end
				S_INS_END: begin
					if (req_kind_t'(req_q.req_type) == REQ_FREE) begin
						state_q <= S_DONE;
						if (ins_ok_q) begin
							gvalid_q[slot_q] <= 1'b0;
							avail_q          <= avail_q + cur_len_q;
							ftally_q         <= ftally_q + 32'd1;
							status_q         <= ST_OK;
						end else
							status_q <= ST_TABLE_FULL;
					end else begin
						if (ins_ok_q)
							total_q <= total_q + {1'b0, cur_len_q};
						region_q <= region_q + 2'd1;
						state_q  <= S_INI_REG;
					end
				end
				// free: look the address up in the grant table
				S_FRE_RD: begin
					if (k_q == MAX_GNT_C) begin
						status_q <= ST_NOT_ALLOC;
						state_q  <= S_DONE;
					end else
						state_q <= S_FRE_CMP;
				end
				S_FRE_CMP: begin
					if (gvalid_q[k_q[GNT_IDX_W-1:0]]
						&& (({1'b0, g_base} + 33'(HDR_SIZE)) == {1'b0, req_q.free_addr})) begin
						slot_q     <= k_q[GNT_IDX_W-1:0];
						cur_base_q <= g_base;
						cur_len_q  <= g_len;
						k_q        <= '0;
						state_q    <= S_INS_RD;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_FRE_RD;
					end
				end
				// init: one region at a time
				S_INI_REG: begin
					if (region_q >= region_count_q) begin
						usable_q    <= total_q[31:0];
						avail_q     <= total_q[31:0];
						min_avail_q <= total_q[31:0];
						atally_q    <= '0;
						ftally_q    <= '0;
						ready_q     <= 1'b1;
						status_q    <= ST_OK;
						state_q     <= S_DONE;
					end else begin
						logic [32:0] start;
						start = ({1'b0, sel_base} + 33'(ALIGN_BYTES - 1)) & ~33'(ALIGN_BYTES - 1);
						if (start[32])
							region_q <= region_q + 2'd1;
						else begin
							cur_base_q <= start[31:0];
							adj_q      <= start[31:0] - sel_base;
							state_q    <= S_INI_USE;
						end
					end
				end
				S_INI_USE: begin
					logic [32:0] room;
					logic [32:0] usable;
					room   = {1'b0, sel_bytes - adj_q};
					if ((room - 33'd1) > {1'b0, ~cur_base_q})
						room = {1'b0, ~cur_base_q} + 33'd1;
					usable = room & ~33'(ALIGN_BYTES - 1);
					if ((sel_bytes <= adj_q) || (usable < {1'b0, MIN_SPLIT})) begin
						region_q <= region_q + 2'd1;
						state_q  <= S_INI_REG;
					end else begin
						cur_len_q <= usable[31:0];
						k_q       <= '0;
						state_q   <= S_OVL_RD;
					end
				end
				S_OVL_RD: begin
					if (k_q >= used_q)
						state_q <= S_INI_TOT;
					else
						state_q <= S_OVL_CMP;
				end
				S_OVL_CMP: begin
					if (({1'b0, cur_base_q} < ({1'b0, rd_base} + {1'b0, rd_len}))
						&& ({1'b0, rd_base} < ({1'b0, cur_base_q} + {1'b0, cur_len_q}))) begin
						region_q <= region_q + 2'd1;
						state_q  <= S_INI_REG;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_OVL_RD;
					end
				end
				S_INI_TOT: begin
					if ((total_q + {1'b0, cur_len_q}) > 33'h0_FFFF_FFFF) begin
						region_q <= region_q + 2'd1;
						state_q  <= S_INI_REG;
					end else begin
						k_q     <= '0;
						state_q <= S_INS_RD;
					end
				end
				// statistics scan
				S_STA_RD: begin
					if (k_q >= used_q)
						state_q <= S_DONE;
					else
						state_q <= S_STA_CMP;
				end
				S_STA_CMP: begin
					if (count_q == '0 || rd_len > largest_q)
						largest_q <= rd_len;
					if (count_q == '0 || rd_len < smallest_q)
						smallest_q <= rd_len;
					count_q <= count_q + CNT_W'(1);
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_STA_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker
// port-level checks of the first-fit heap allocator
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input res_t out_data,
	input logic out_valid,
	input logic out_stall
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// in-use plus free always adds up to the heap size
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.occupied_bytes + out_data.free_bytes)
			== out_data.heap_total_bytes)
		else $error("occupied and free bytes do not sum to heap total");

	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.lowest_free_seen <= out_data.free_bytes)
		else $error("low-water mark above free bytes");

	// only a good allocate returns an address
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.granted_addr != '0 |-> out_data.status == ST_OK)
		else $error("address granted with failing status");

	// one request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_data  (out_data),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
